### design/fbfp_pkg.sv
// Package with the constants, types and piece decoding for the FEN board field parser.
package fbfp_pkg;

	localparam int BOARD_SIZE = 8;
	localparam int CNT_W = 4;
	localparam logic [CNT_W-1:0] BOARD_LIMIT = CNT_W'(BOARD_SIZE);

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_UP_A  = 8'h41;
	localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
	localparam logic [7:0] CHAR_LO_A  = 8'h61;
	localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
	localparam logic [7:0] CASE_BIT   = 8'h20;

	typedef enum logic [2:0] {
		PIECE_PAWN   = 3'd0,
		PIECE_ROOK   = 3'd1,
		PIECE_KNIGHT = 3'd2,
		PIECE_BISHOP = 3'd3,
		PIECE_QUEEN  = 3'd4,
		PIECE_KING   = 3'd5
	} piece_t;

	typedef struct packed {
		logic       hit;
		piece_t     kind;
	} piece_dec_t;

	typedef struct packed {
		logic [2:0] file_index;
		logic [2:0] rank_index;
		logic [2:0] piece_type;
		logic       is_white;
	} result_t;

	// Maps a lowercase letter to its piece; hit is low for any other letter.
	function automatic piece_dec_t decode_piece(input logic [7:0] lower);
		piece_dec_t d;
		d.hit  = 1'b1;
		d.kind = PIECE_PAWN;
		case (lower)
			8'h70: d.kind = PIECE_PAWN;
			8'h72: d.kind = PIECE_ROOK;
			8'h6E: d.kind = PIECE_KNIGHT;
			8'h62: d.kind = PIECE_BISHOP;
			8'h71: d.kind = PIECE_QUEEN;
			8'h6B: d.kind = PIECE_KING;
			default: d.hit = 1'b0;
		endcase
		return d;
	endfunction

endpackage

### design/fen_board_field_parser_top.sv
// Top level of the FEN board field parser: parse state, result register and skid stage.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+---------------------------------------------
//  input   | in_valid  | in_stall  | symbol, start_req
//  output  | out_valid | out_stall | file_index, rank_index, piece_type, is_white
//
// One character is taken per cycle unless the input stalls; an accepted piece is
// registered in the output stage, or in the skid stage if the output stalls. The
// counters are updated in the accepting cycle, so the only loop is the small file
// and rank update. Reset clears the parse state and both stages' valid flags. An
// output stall goes into the skid stage; the input stalls only while it holds a result.
module fen_board_field_parser_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] symbol,
	input  logic       start_req,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] file_index,
	output logic [2:0] rank_index,
	output logic [2:0] piece_type,
	output logic       is_white
);

	localparam int CW = fbfp_pkg::CNT_W;

	logic [CW-1:0] rank_count_q, file_count_q;
	logic          skipping_rank_q, parse_finished_q;

	logic [CW-1:0] rank_cur, file_cur, rank_nxt, file_nxt, rank_inc, room, digit_val;
	logic          skip_cur, fin_cur, skip_nxt, fin_nxt;
	logic          is_upper, is_lower, is_digit, emit;
	logic [7:0]    lower_char;
	fbfp_pkg::piece_dec_t dec;
	fbfp_pkg::result_t    res_new;

	logic                 out_valid_q, skid_valid_q;
	fbfp_pkg::result_t    out_q, skid_q;
	logic                 accept, out_take;

	assign in_stall = skid_valid_q;
	assign accept   = in_valid && !skid_valid_q;
	assign out_take = out_valid_q && !out_stall;

	assign is_upper   = (symbol >= fbfp_pkg::CHAR_UP_A) && (symbol <= fbfp_pkg::CHAR_UP_Z);
	assign is_lower   = (symbol >= fbfp_pkg::CHAR_LO_A) && (symbol <= fbfp_pkg::CHAR_LO_Z);
	assign is_digit   = (symbol >= fbfp_pkg::CHAR_ZERO) && (symbol <= fbfp_pkg::CHAR_NINE);
	assign lower_char = symbol | fbfp_pkg::CASE_BIT;
	assign dec        = fbfp_pkg::decode_piece(lower_char);
	assign digit_val  = CW'(symbol - fbfp_pkg::CHAR_ZERO);

	always_comb begin
		// A start request clears the parse state before the character is handled.
		rank_cur = start_req ? '0 : rank_count_q;
		file_cur = start_req ? '0 : file_count_q;
		skip_cur = start_req ? 1'b0 : skipping_rank_q;
		fin_cur  = start_req ? 1'b0 : parse_finished_q;

		rank_nxt = rank_cur;
		file_nxt = file_cur;
		skip_nxt = skip_cur;
		fin_nxt  = fin_cur;
		emit     = 1'b0;
		rank_inc = rank_cur + CW'(1);
		room     = (file_cur < fbfp_pkg::BOARD_LIMIT) ? fbfp_pkg::BOARD_LIMIT - file_cur : '0;

		res_new.file_index = file_cur[2:0];
		res_new.rank_index = rank_cur[2:0];
		res_new.piece_type = dec.kind;
		res_new.is_white   = is_upper;

		if (!fin_cur) begin
			if (symbol == fbfp_pkg::CHAR_SPACE) begin
				fin_nxt = 1'b1;
			end else if (symbol == fbfp_pkg::CHAR_SLASH) begin
				rank_nxt = rank_inc;
				file_nxt = '0;
				skip_nxt = 1'b0;
				fin_nxt  = (rank_inc >= fbfp_pkg::BOARD_LIMIT);
			end else if (!skip_cur) begin
				if (is_digit) begin
					file_nxt = file_cur + ((digit_val > room) ? room : digit_val);
				end else if (is_upper || is_lower) begin
					if (file_cur >= fbfp_pkg::BOARD_LIMIT) begin
						skip_nxt = 1'b1;
					end else begin
						file_nxt = file_cur + CW'(1);
						emit     = dec.hit;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_count_q     <= '0;
			file_count_q     <= '0;
			skipping_rank_q  <= 1'b0;
			parse_finished_q <= 1'b0;
		end else if (accept) begin
			rank_count_q     <= rank_nxt;
			file_count_q     <= file_nxt;
			skipping_rank_q  <= skip_nxt;
			parse_finished_q <= fin_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (out_take) begin
					skid_valid_q <= 1'b0;
				end
			end else if (accept && emit) begin
				if (out_valid_q && !out_take) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_q <= skid_q;
			end
		end else if (accept && emit) begin
			if (out_valid_q && !out_take) begin
				skid_q <= res_new;
			end else begin
				out_q <= res_new;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign file_index = out_q.file_index;
	assign rank_index = out_q.rank_index;
	assign piece_type = out_q.piece_type;
	assign is_white   = out_q.is_white;

endmodule
